// ----- hw/rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C bit-level master.
// Used by i2cm_core and i2c_bit_level_master_top; depends on nothing else.
package i2cm_pkg;

    // Width of the half-period delay counter
    localparam int DELAY_WIDTH = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // Read and bus-reset bit counts
    localparam logic [3:0] READ_BITS  = 4'd8;
    localparam logic [3:0] RESET_BITS = 4'd9;

    // Request kinds; the last code is ignored
    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_START     = 3'd1,
        KIND_STOP      = 3'd2,
        KIND_WRITE     = 3'd3,
        KIND_READ      = 3'd4,
        KIND_CHECK_ACK = 3'd5,
        KIND_BUS_RESET = 3'd6,
        KIND_UNUSED    = 3'd7
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_TIMEOUT = 2'd1,
        STAT_BUSY    = 2'd2
    } t_status;

    // Sequencer phases, one-hot
    typedef enum logic [28:0] {
        PH_IDLE     = 29'h1 << 0,
        PH_ST       = 29'h1 << 1,
        PH_ST_2     = 29'h1 << 2,
        PH_RS_ST1   = 29'h1 << 3,
        PH_RS_ST1_2 = 29'h1 << 4,
        PH_RS_ST2   = 29'h1 << 5,
        PH_RS_ST2_2 = 29'h1 << 6,
        PH_SP       = 29'h1 << 7,
        PH_SP_2     = 29'h1 << 8,
        PH_SP_3     = 29'h1 << 9,
        PH_TO       = 29'h1 << 10,
        PH_TO_2     = 29'h1 << 11,
        PH_TO_3     = 29'h1 << 12,
        PH_RSP      = 29'h1 << 13,
        PH_RSP_2    = 29'h1 << 14,
        PH_RSP_3    = 29'h1 << 15,
        PH_WR_PRE   = 29'h1 << 16,
        PH_WR_HI    = 29'h1 << 17,
        PH_WR_LO    = 29'h1 << 18,
        PH_RD_LO    = 29'h1 << 19,
        PH_RD_HI    = 29'h1 << 20,
        PH_AK_LO    = 29'h1 << 21,
        PH_AK_HI    = 29'h1 << 22,
        PH_CK_A     = 29'h1 << 23,
        PH_CK_B     = 29'h1 << 24,
        PH_CK_POLL  = 29'h1 << 25,
        PH_RC_LO1   = 29'h1 << 26,
        PH_RC_HI    = 29'h1 << 27,
        PH_RC_LO2   = 29'h1 << 28
    } t_phase;

    // One result of the sequencer
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_oe;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       slave_ack;
        t_status    status;
    } t_result;

endpackage

// ----- hw/rtl/i2c_bit_level_master_top.sv -----
// I2C bit-level master, top level: configuration registers, request handshake
// and result register. Depends on i2cm_pkg and i2cm_core.

// The block takes one request per clock cycle unless stalled, ticks and
// commands alike, and each request gives exactly one result, loaded into the
// result register when the request is taken. The sequencer state is updated
// in a single registered step per request; a new request is taken in the same
// cycle that the held result leaves, so throughput is one request per cycle
// whenever the result side takes one per cycle, and requests stall only while
// a held result is stalled. Commands sent while a sequence runs are refused
// with the busy status. Write the configuration only while idle.
module i2c_bit_level_master_top
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_master_ack,
    input  logic        i_sda_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic        o_sda_oe,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_slave_ack,
    output logic [1:0]  o_status,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;
    logic        r_out_valid;
    t_result     r_result;
    t_result     core_result;
    logic        take;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data;
            end else begin
                r_ack_timeout <= i_cfg_data[7:0];
            end
        end
    end

    // Stall the request side only while a held result is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .i_master_ack  (i_master_ack),
        .i_sda_in      (i_sda_in),
        .i_half_period (r_half_period),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (core_result)
    );

    // Track the result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= take || (r_out_valid && i_out_stall);
        end
    end

    // Load the result of each taken request
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl       = r_result.scl;
    assign o_sda_out   = r_result.sda_out;
    assign o_sda_oe    = r_result.sda_oe;
    assign o_busy_res  = r_result.busy;
    assign o_done_res  = r_result.done;
    assign o_read_data = r_result.read_data;
    assign o_slave_ack = r_result.slave_ack;
    assign o_status    = r_result.status;

endmodule

// ----- hw/rtl/i2cm_core.sv -----
// Pin sequencer of the I2C bit-level master: phase state, counters and pin levels.
// Depends on i2cm_pkg; one request advances the state by one step.
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_master_ack,
    input  logic        i_sda_in,
    input  logic [15:0] i_half_period,
    input  logic [7:0]  i_ack_timeout,
    output t_result     o_result
);

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_bit_count, n_bit_count;
    logic [7:0]             r_shift_byte, n_shift_byte;
    logic [DELAY_WIDTH-1:0] r_delay_count, n_delay_count;
    logic [7:0]             r_timeout_count, n_timeout_count;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_sda_drive, n_sda_drive;
    logic                   r_ack_flag, n_ack_flag;
    logic                   r_ack_choice, n_ack_choice;
    logic [7:0]             r_last_read, n_last_read;
    logic                   done;
    t_status                status;
    logic [DELAY_WIDTH-1:0] delay_load;

    assign delay_load = DELAY_WIDTH'(i_half_period);

    // Compute the next state for the request at the input
    always_comb begin
        n_phase         = r_phase;
        n_bit_count     = r_bit_count;
        n_shift_byte    = r_shift_byte;
        n_delay_count   = r_delay_count;
        n_timeout_count = r_timeout_count;
        n_scl           = r_scl;
        n_sda           = r_sda;
        n_sda_drive     = r_sda_drive;
        n_ack_flag      = r_ack_flag;
        n_ack_choice    = r_ack_choice;
        n_last_read     = r_last_read;
        done            = 1'b0;
        status          = STAT_OK;

        if (i_kind == KIND_TICK) begin
            if (r_phase == PH_IDLE) begin
                // idle tick changes nothing
            end else if (r_phase == PH_CK_POLL) begin
                // poll SDA for the slave acknowledge
                if (!i_sda_in) begin
                    n_scl      = 1'b0;
                    n_ack_flag = 1'b1;
                    n_phase    = PH_IDLE;
                    done       = 1'b1;
                end else if (r_timeout_count >= i_ack_timeout) begin
                    n_ack_flag    = 1'b0;
                    n_sda_drive   = 1'b1;
                    n_scl         = 1'b0;
                    n_sda         = 1'b0;
                    n_phase       = PH_TO;
                    n_delay_count = delay_load;
                end else begin
                    n_timeout_count = r_timeout_count + 8'd1;
                end
            end else if (r_delay_count > DELAY_WIDTH'(1)) begin
                n_delay_count = r_delay_count - DELAY_WIDTH'(1);
            end else begin
                // end of a delay phase
                n_delay_count = '0;
                unique case (r_phase)
                    PH_ST, PH_RS_ST1, PH_RS_ST2: begin
                        n_sda         = 1'b0;
                        n_delay_count = delay_load;
                        n_phase       = (r_phase == PH_ST)     ? PH_ST_2 :
                                        (r_phase == PH_RS_ST1) ? PH_RS_ST1_2 : PH_RS_ST2_2;
                    end
                    PH_ST_2: begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    PH_RS_ST1_2: begin
                        n_scl         = 1'b0;
                        n_sda_drive   = 1'b1;
                        n_sda         = 1'b1;
                        n_bit_count   = '0;
                        n_phase       = PH_RC_LO1;
                        n_delay_count = delay_load;
                    end
                    PH_RS_ST2_2: begin
                        n_sda_drive   = 1'b1;
                        n_scl         = 1'b0;
                        n_sda         = 1'b0;
                        n_phase       = PH_RSP;
                        n_delay_count = delay_load;
                    end
                    PH_SP, PH_TO, PH_RSP: begin
                        n_scl         = 1'b1;
                        n_delay_count = delay_load;
                        n_phase       = (r_phase == PH_SP) ? PH_SP_2 :
                                        (r_phase == PH_TO) ? PH_TO_2 : PH_RSP_2;
                    end
                    PH_SP_2, PH_TO_2, PH_RSP_2: begin
                        n_sda         = 1'b1;
                        n_delay_count = delay_load;
                        n_phase       = (r_phase == PH_SP_2) ? PH_SP_3 :
                                        (r_phase == PH_TO_2) ? PH_TO_3 : PH_RSP_3;
                    end
                    PH_SP_3, PH_TO_3, PH_RSP_3: begin
                        if (r_phase == PH_TO_3) begin
                            status = STAT_TIMEOUT;
                        end
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    PH_WR_PRE: begin
                        n_bit_count   = '0;
                        n_sda         = r_shift_byte[7];
                        n_shift_byte  = {r_shift_byte[6:0], 1'b0};
                        n_scl         = 1'b1;
                        n_phase       = PH_WR_HI;
                        n_delay_count = delay_load;
                    end
                    PH_WR_HI: begin
                        n_scl         = 1'b0;
                        n_phase       = PH_WR_LO;
                        n_delay_count = delay_load;
                    end
                    PH_WR_LO: begin
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count >= READ_BITS) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_sda         = r_shift_byte[7];
                            n_shift_byte  = {r_shift_byte[6:0], 1'b0};
                            n_scl         = 1'b1;
                            n_phase       = PH_WR_HI;
                            n_delay_count = delay_load;
                        end
                    end
                    PH_RD_LO: begin
                        // sample on the rising SCL edge
                        n_scl         = 1'b1;
                        n_shift_byte  = {r_shift_byte[6:0], i_sda_in};
                        n_bit_count   = r_bit_count + 4'd1;
                        n_phase       = PH_RD_HI;
                        n_delay_count = delay_load;
                    end
                    PH_RD_HI: begin
                        n_scl         = 1'b0;
                        n_delay_count = delay_load;
                        if (r_bit_count < READ_BITS) begin
                            n_phase = PH_RD_LO;
                        end else begin
                            n_sda_drive = 1'b1;
                            n_sda       = ~r_ack_choice;
                            n_phase     = PH_AK_LO;
                        end
                    end
                    PH_AK_LO: begin
                        n_scl         = 1'b1;
                        n_phase       = PH_AK_HI;
                        n_delay_count = delay_load;
                    end
                    PH_AK_HI: begin
                        n_scl       = 1'b0;
                        n_last_read = r_shift_byte;
                        n_phase     = PH_IDLE;
                        done        = 1'b1;
                    end
                    PH_CK_A: begin
                        n_scl         = 1'b1;
                        n_phase       = PH_CK_B;
                        n_delay_count = delay_load;
                    end
                    PH_CK_B: begin
                        n_timeout_count = '0;
                        n_phase         = PH_CK_POLL;
                    end
                    PH_RC_LO1: begin
                        n_scl         = 1'b1;
                        n_phase       = PH_RC_HI;
                        n_delay_count = delay_load;
                    end
                    PH_RC_HI: begin
                        n_scl         = 1'b0;
                        n_phase       = PH_RC_LO2;
                        n_delay_count = delay_load;
                    end
                    PH_RC_LO2: begin
                        n_bit_count   = r_bit_count + 4'd1;
                        n_delay_count = delay_load;
                        if (n_bit_count >= RESET_BITS) begin
                            n_sda_drive = 1'b1;
                            n_sda       = 1'b1;
                            n_scl       = 1'b1;
                            n_phase     = PH_RS_ST2;
                        end else begin
                            n_phase = PH_RC_LO1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else if (i_kind != KIND_UNUSED) begin
            if (r_phase != PH_IDLE) begin
                // refuse a command while a sequence runs
                status = STAT_BUSY;
            end else begin
                n_delay_count = delay_load;
                unique case (i_kind)
                    KIND_START: begin
                        n_sda_drive = 1'b1;
                        n_sda       = 1'b1;
                        n_scl       = 1'b1;
                        n_phase     = PH_ST;
                    end
                    KIND_STOP: begin
                        n_sda_drive = 1'b1;
                        n_scl       = 1'b0;
                        n_sda       = 1'b0;
                        n_phase     = PH_SP;
                    end
                    KIND_WRITE: begin
                        n_sda_drive  = 1'b1;
                        n_scl        = 1'b0;
                        n_shift_byte = i_data_byte;
                        n_phase      = PH_WR_PRE;
                    end
                    KIND_READ: begin
                        n_sda_drive  = 1'b0;
                        n_sda        = 1'b1;
                        n_scl        = 1'b0;
                        n_bit_count  = '0;
                        n_shift_byte = '0;
                        n_ack_choice = i_master_ack;
                        n_phase      = PH_RD_LO;
                    end
                    KIND_CHECK_ACK: begin
                        n_sda_drive = 1'b0;
                        n_sda       = 1'b1;
                        n_phase     = PH_CK_A;
                    end
                    default: begin
                        n_sda_drive = 1'b1;
                        n_sda       = 1'b1;
                        n_scl       = 1'b1;
                        n_phase     = PH_RS_ST1;
                    end
                endcase
            end
        end
    end

    // Hold the state until a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_bit_count     <= '0;
            r_shift_byte    <= '0;
            r_delay_count   <= '0;
            r_timeout_count <= '0;
            r_scl           <= 1'b1;
            r_sda           <= 1'b1;
            r_sda_drive     <= 1'b1;
            r_ack_flag      <= 1'b0;
            r_ack_choice    <= 1'b0;
            r_last_read     <= '0;
        end else if (i_take) begin
            r_phase         <= n_phase;
            r_bit_count     <= n_bit_count;
            r_shift_byte    <= n_shift_byte;
            r_delay_count   <= n_delay_count;
            r_timeout_count <= n_timeout_count;
            r_scl           <= n_scl;
            r_sda           <= n_sda;
            r_sda_drive     <= n_sda_drive;
            r_ack_flag      <= n_ack_flag;
            r_ack_choice    <= n_ack_choice;
            r_last_read     <= n_last_read;
        end
    end

    // Form the result from the state after this request
    always_comb begin
        o_result.scl       = n_scl;
        o_result.sda_out   = n_sda_drive ? n_sda : 1'b1;
        o_result.sda_oe    = n_sda_drive;
        o_result.busy      = (n_phase != PH_IDLE);
        o_result.done      = done;
        o_result.read_data = n_last_read;
        o_result.slave_ack = n_ack_flag;
        o_result.status    = status;
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the I2C bit-level master top level.
// Depends on i2cm_pkg and i2c_bit_level_master_top; predicts every result
// from its own copy of the sequencer state and checks it field by field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int RANDOM_REQUESTS = 650;
    localparam int NEVER_ACK       = 1000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT  = 1000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_kind       = KIND_TICK;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_master_ack = 1'b0;
    logic        i_sda_in     = 1'b1;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic        o_scl;
    logic        o_sda_out;
    logic        o_sda_oe;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_data;
    logic        o_slave_ack;
    logic [1:0]  o_status;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index  = CFG_HALF_PERIOD;
    logic [15:0] i_cfg_data   = 16'h0000;

    i2c_bit_level_master_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_master_ack (i_master_ack),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scl        (o_scl),
        .o_sda_out    (o_sda_out),
        .o_sda_oe     (o_sda_oe),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_data  (o_read_data),
        .o_slave_ack  (o_slave_ack),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted sequencer state and configuration
    t_phase      bus_phase   = PH_IDLE;
    logic [3:0]  bit_cnt     = 4'd0;
    logic [7:0]  shreg       = 8'h00;
    logic [15:0] delay_left  = 16'd0;
    logic [7:0]  poll_cnt    = 8'd0;
    logic        scl_lvl     = 1'b1;
    logic        sda_lvl     = 1'b1;
    logic        sda_drv     = 1'b1;
    logic        ack_seen    = 1'b0;
    logic        ack_reply   = 1'b0;
    logic [7:0]  read_byte   = 8'h00;
    logic [15:0] cfg_half    = HALF_PERIOD_RESET;
    logic [7:0]  cfg_timeout = ACK_TIMEOUT_RESET;

    t_result pin_results[$];
    t_result oldest;
    int      mismatches    = 0;
    int      requests_sent = 0;
    int      stall_run     = 0;
    int      idle_cycles   = 0;
    bit      quiet         = 1'b0;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    // Enter a delay phase and reload the half-period counter
    function automatic void enter(t_phase ph);
        bus_phase  = ph;
        delay_left = cfg_half;
    endfunction

    function automatic void go_start(t_phase ph);
        sda_drv = 1'b1;
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
        enter(ph);
    endfunction

    function automatic void go_stop(t_phase ph);
        sda_drv = 1'b1;
        scl_lvl = 1'b0;
        sda_lvl = 1'b0;
        enter(ph);
    endfunction

    // Put the next data bit on SDA, MSB first, and raise SCL
    function automatic void shift_out_bit();
        sda_lvl = shreg[7];
        shreg   = {shreg[6:0], 1'b0};
        scl_lvl = 1'b1;
        enter(PH_WR_HI);
    endfunction

    // Advance the predicted master by one request and return its result
    function automatic t_result step_master(input logic [2:0] kind, input logic [7:0] data,
                                            input logic mack, input logic sda);
        t_result r;
        logic    done;
        t_status st;
        done = 1'b0;
        st   = STAT_OK;
        if (kind == KIND_TICK) begin
            if (bus_phase == PH_IDLE) begin
                done = 1'b0;
            end else if (bus_phase == PH_CK_POLL) begin
                if (!sda) begin
                    scl_lvl   = 1'b0;
                    ack_seen  = 1'b1;
                    bus_phase = PH_IDLE;
                    done      = 1'b1;
                end else if (poll_cnt >= cfg_timeout) begin
                    ack_seen = 1'b0;
                    go_stop(PH_TO);
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end else if (delay_left > 16'd1) begin
                delay_left = delay_left - 16'd1;
            end else begin
                delay_left = 16'd0;
                case (bus_phase)
                    PH_ST: begin
                        sda_lvl = 1'b0;
                        enter(PH_ST_2);
                    end
                    PH_RS_ST1: begin
                        sda_lvl = 1'b0;
                        enter(PH_RS_ST1_2);
                    end
                    PH_RS_ST2: begin
                        sda_lvl = 1'b0;
                        enter(PH_RS_ST2_2);
                    end
                    PH_ST_2: begin
                        scl_lvl   = 1'b0;
                        bus_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_RS_ST1_2: begin
                        scl_lvl = 1'b0;
                        sda_drv = 1'b1;
                        sda_lvl = 1'b1;
                        bit_cnt = 4'd0;
                        enter(PH_RC_LO1);
                    end
                    PH_RS_ST2_2: begin
                        scl_lvl = 1'b0;
                        go_stop(PH_RSP);
                    end
                    PH_SP: begin
                        scl_lvl = 1'b1;
                        enter(PH_SP_2);
                    end
                    PH_TO: begin
                        scl_lvl = 1'b1;
                        enter(PH_TO_2);
                    end
                    PH_RSP: begin
                        scl_lvl = 1'b1;
                        enter(PH_RSP_2);
                    end
                    PH_SP_2: begin
                        sda_lvl = 1'b1;
                        enter(PH_SP_3);
                    end
                    PH_TO_2: begin
                        sda_lvl = 1'b1;
                        enter(PH_TO_3);
                    end
                    PH_RSP_2: begin
                        sda_lvl = 1'b1;
                        enter(PH_RSP_3);
                    end
                    PH_SP_3, PH_RSP_3: begin
                        bus_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_TO_3: begin
                        st        = STAT_TIMEOUT;
                        bus_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_WR_PRE: begin
                        bit_cnt = 4'd0;
                        shift_out_bit();
                    end
                    PH_WR_HI: begin
                        scl_lvl = 1'b0;
                        enter(PH_WR_LO);
                    end
                    PH_WR_LO: begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= 4'd8) begin
                            bus_phase = PH_IDLE;
                            done      = 1'b1;
                        end else begin
                            shift_out_bit();
                        end
                    end
                    // Sample SDA as SCL rises
                    PH_RD_LO: begin
                        scl_lvl = 1'b1;
                        shreg   = {shreg[6:0], sda};
                        bit_cnt = bit_cnt + 4'd1;
                        enter(PH_RD_HI);
                    end
                    PH_RD_HI: begin
                        scl_lvl = 1'b0;
                        if (bit_cnt < READ_BITS) begin
                            enter(PH_RD_LO);
                        end else begin
                            sda_drv = 1'b1;
                            sda_lvl = !ack_reply;
                            enter(PH_AK_LO);
                        end
                    end
                    PH_AK_LO: begin
                        scl_lvl = 1'b1;
                        enter(PH_AK_HI);
                    end
                    PH_AK_HI: begin
                        scl_lvl   = 1'b0;
                        read_byte = shreg;
                        bus_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_CK_A: begin
                        scl_lvl = 1'b1;
                        enter(PH_CK_B);
                    end
                    PH_CK_B: begin
                        poll_cnt  = 8'd0;
                        bus_phase = PH_CK_POLL;
                    end
                    PH_RC_LO1: begin
                        scl_lvl = 1'b1;
                        enter(PH_RC_HI);
                    end
                    PH_RC_HI: begin
                        scl_lvl = 1'b0;
                        enter(PH_RC_LO2);
                    end
                    PH_RC_LO2: begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= RESET_BITS) go_start(PH_RS_ST2);
                        else enter(PH_RC_LO1);
                    end
                    default: bus_phase = PH_IDLE;
                endcase
            end
        end else if (kind != KIND_UNUSED) begin
            // Refuse commands while a sequence runs
            if (bus_phase != PH_IDLE) begin
                st = STAT_BUSY;
            end else begin
                case (kind)
                    KIND_START: go_start(PH_ST);
                    KIND_STOP:  go_stop(PH_SP);
                    KIND_WRITE: begin
                        sda_drv = 1'b1;
                        scl_lvl = 1'b0;
                        shreg   = data;
                        enter(PH_WR_PRE);
                    end
                    KIND_READ: begin
                        sda_drv   = 1'b0;
                        sda_lvl   = 1'b1;
                        scl_lvl   = 1'b0;
                        bit_cnt   = 4'd0;
                        shreg     = 8'h00;
                        ack_reply = mack;
                        enter(PH_RD_LO);
                    end
                    KIND_CHECK_ACK: begin
                        sda_drv = 1'b0;
                        sda_lvl = 1'b1;
                        enter(PH_CK_A);
                    end
                    default: go_start(PH_RS_ST1);
                endcase
            end
        end
        r.scl       = scl_lvl;
        r.sda_out   = sda_drv ? sda_lvl : 1'b1;
        r.sda_oe    = sda_drv;
        r.busy      = (bus_phase != PH_IDLE);
        r.done      = done;
        r.read_data = read_byte;
        r.slave_ack = ack_seen;
        r.status    = st;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pin_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request outstanding", $time);
            end else begin
                oldest = pin_results.pop_front();
                check_field("scl", oldest.scl, o_scl);
                check_field("sda_out", oldest.sda_out, o_sda_out);
                check_field("sda_oe", oldest.sda_oe, o_sda_oe);
                check_field("busy", oldest.busy, o_busy_res);
                check_field("done", oldest.done, o_done_res);
                check_field("read_data", oldest.read_data, o_read_data);
                check_field("slave_ack", oldest.slave_ack, o_slave_ack);
                check_field("status", oldest.status, o_status);
            end
        end
    end

    // Stall the result side in random runs
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (quiet || $urandom_range(0, 2) != 0) begin
            i_out_stall <= 1'b0;
            stall_run   <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b1;
            stall_run   <= pick_gap() - 1;
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request, hold it until taken, then predict its result
    task automatic send_item(input logic [2:0] kind, input logic [7:0] data,
                             input logic mack, input logic sda);
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_data_byte  <= data;
        i_master_ack <= mack;
        i_sda_in     <= sda;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pin_results.push_back(step_master(kind, data, mack, sda));
        requests_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // Hold off requests until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pin_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD) cfg_half = value;
        else cfg_timeout = value[7:0];
    endtask

    // Tick until the sequence ends; SDA stays high for ack_after polls
    task automatic run_sequence(input int ack_after, input int noise_pct);
        int polls;
        polls = 0;
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(3'($urandom_range(1, 6)), 8'($urandom), 1'($urandom), 1'($urandom));
            if (bus_phase == PH_CK_POLL) begin
                send_item(KIND_TICK, 8'($urandom), 1'($urandom), polls < ack_after);
                polls++;
            end else begin
                send_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic do_command(input logic [2:0] kind, input logic [7:0] data, input logic mack,
                              input int ack_after, input int noise_pct);
        send_item(kind, data, mack, 1'($urandom));
        run_sequence(ack_after, noise_pct);
    endtask

    // Mostly quick ACKs, some at the timeout edge, some never
    function automatic int pick_ack();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 2);
            6, 7:             return cfg_timeout + $urandom_range(0, 1);
            8:                return NEVER_ACK;
            default:          return $urandom_range(0, 8);
        endcase
    endfunction

    // Start with the reset period, then run out the reset timeout on a short period
    task automatic test_reset_config();
        do_command(KIND_START, 8'h00, 1'b0, 0, 0);
        write_cfg(CFG_HALF_PERIOD, 16'd1);
        do_command(KIND_CHECK_ACK, 8'hFF, 1'b1, NEVER_ACK, 0);
    endtask

    // Walk every command, the busy refusal, idle ticks and the unused kind
    task automatic test_commands();
        write_cfg(CFG_HALF_PERIOD, 16'd1);
        write_cfg(CFG_ACK_TIMEOUT, 16'd4);
        send_item(KIND_TICK, 8'hFF, 1'b1, 1'b0);
        send_item(KIND_TICK, 8'h00, 1'b0, 1'b1);
        send_item(KIND_UNUSED, 8'h5A, 1'b1, 1'b1);
        send_item(KIND_START, 8'h00, 1'b0, 1'b1);
        send_item(KIND_STOP, 8'h12, 1'b0, 1'b0);
        send_item(KIND_BUS_RESET, 8'h00, 1'b1, 1'b1);
        send_item(KIND_UNUSED, 8'hFF, 1'b0, 1'b0);
        run_sequence(0, 0);
        do_command(KIND_WRITE, 8'hFF, 1'b0, 0, 0);
        do_command(KIND_CHECK_ACK, 8'h00, 1'b0, 0, 0);
        do_command(KIND_WRITE, 8'h00, 1'b1, 0, 0);
        // last high poll that still allows an ACK
        do_command(KIND_CHECK_ACK, 8'h00, 1'b0, 4, 0);
        do_command(KIND_WRITE, 8'h80, 1'b0, 0, 0);
        // one high poll too many
        do_command(KIND_CHECK_ACK, 8'h00, 1'b1, 5, 0);
        do_command(KIND_READ, 8'h00, 1'b1, 0, 0);
        do_command(KIND_READ, 8'hFF, 1'b0, 0, 0);
        do_command(KIND_STOP, 8'h00, 1'b0, 0, 0);
        do_command(KIND_BUS_RESET, 8'h00, 1'b0, 0, 0);
        do_command(KIND_CHECK_ACK, 8'h00, 1'b0, 0, 20);
    endtask

    // Largest timeout, a timeout of one, and a short period
    task automatic test_extremes();
        write_cfg(CFG_ACK_TIMEOUT, 16'd255);
        do_command(KIND_CHECK_ACK, 8'h00, 1'b0, 255, 0);
        write_cfg(CFG_ACK_TIMEOUT, 16'd1);
        do_command(KIND_CHECK_ACK, 8'h00, 1'b0, 1, 0);
        do_command(KIND_CHECK_ACK, 8'h00, 1'b0, 2, 0);
        write_cfg(CFG_HALF_PERIOD, 16'd2);
        do_command(KIND_WRITE, 8'h01, 1'b0, 0, 0);
    endtask

    // Mostly well-formed transfers with random content, plus broken ones
    task automatic test_random_traffic();
        int          stop_at;
        int          noise_pct;
        logic [15:0] period;
        stop_at = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: period = 16'd1;
                    5, 6, 7:       period = 16'($urandom_range(2, 4));
                    8:             period = 16'($urandom_range(5, 12));
                    default:       period = 16'($urandom_range(13, 40));
                endcase
                write_cfg(CFG_HALF_PERIOD, period);
                write_cfg(CFG_ACK_TIMEOUT,
                          ($urandom_range(0, 4) == 0) ? 16'd255 : 16'($urandom_range(1, 8)));
            end
            quiet     = ($urandom_range(0, 5) == 0);
            noise_pct = ($urandom_range(0, 2) == 0) ? 5 : 0;
            repeat ($urandom_range(0, 2))
                send_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            case ($urandom_range(0, 19))
                0: do_command(KIND_BUS_RESET, 8'($urandom), 1'($urandom), 0, noise_pct);
                1, 2: begin
                    repeat ($urandom_range(1, 3))
                        do_command(3'($urandom_range(1, 6)), 8'($urandom), 1'($urandom),
                                   pick_ack(), noise_pct);
                end
                default: begin
                    do_command(KIND_START, 8'($urandom), 1'($urandom), 0, noise_pct);
                    do_command(KIND_WRITE, 8'($urandom), 1'($urandom), 0, noise_pct);
                    do_command(KIND_CHECK_ACK, 8'($urandom), 1'($urandom), pick_ack(),
                               noise_pct);
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(0, 1) == 0) begin
                            do_command(KIND_WRITE, 8'($urandom), 1'($urandom), 0, noise_pct);
                            do_command(KIND_CHECK_ACK, 8'($urandom), 1'($urandom), pick_ack(),
                                       noise_pct);
                        end else begin
                            do_command(KIND_READ, 8'($urandom), 1'($urandom), 0, noise_pct);
                        end
                    end
                    do_command(KIND_STOP, 8'($urandom), 1'($urandom), 0, noise_pct);
                end
            endcase
            if ($urandom_range(0, 9) == 0) drain_results();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_commands();
        test_extremes();
        test_random_traffic();
        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_core.sv
hw/rtl/i2c_bit_level_master_top.sv
tb/tb.sv
